// ===== rtl/core/crc8cf_pkg.sv =====
// crc8cf_pkg: shared types, constants and the crc-8 byte update for the
// command framer. Depends on nothing; used by crc8_command_framer_unit.

package crc8cf_pkg;

  // frame layout constants
  localparam logic [7:0] FrameHeader   = 8'h5A;
  localparam logic [7:0] FrameOverhead = 8'd6;
  localparam logic [7:0] MaxPayload    = 8'd249;
  localparam logic [7:0] ReservedByte  = 8'h00;
  localparam logic [7:0] CrcPoly       = 8'h8C;
  localparam logic [7:0] DeviceIdReset = 8'h01;

  // next byte of the frame to send for the held item
  typedef enum logic [2:0] {
    PH_HDR,
    PH_LEN,
    PH_DEV,
    PH_CMD,
    PH_DATA,
    PH_RSV,
    PH_CRC
  } phase_e;

  // reflected crc-8 over one byte, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crc8_command_framer_unit.sv =====
// crc8_command_framer_unit: builds command frames with a trailing crc-8.
// Depends on crc8cf_pkg for the phase type, frame constants and crc update.
//
//  channel   | handshake                 | beat contents
//  ----------+---------------------------+-----------------------------------
//  config    | device_id_we_i            | device_id_i
//  input     | in_valid_i / in_ready_o   | command_i, payload_len_i, data_byte_i
//  output    | out_valid_o / out_ready_i | frame_byte_o, frame_end_o
//
// One output byte leaves per cycle while an item is held and the output is not
// stalled; a frame-start item emits 5 bytes (6 for a zero-length frame, 7 for a
// one-byte frame), a payload item 1 byte and the item with the last payload byte 3 bytes.
// The single byte emitter between the input holding register and the output
// register sets this; the next item is taken in the cycle its predecessor's
// last byte is emitted. Reset clears the framer to idle with device id 1.
// A stalled output holds its byte and the emitter waits behind it.

module crc8_command_framer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       device_id_we_i,
  input  logic [7:0] device_id_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] command_i,
  input  logic [7:0] payload_len_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  logic [7:0]          device_id_q;
  logic                hold_valid_q;
  logic [7:0]          cmd_q;
  logic [7:0]          plen_q;
  logic [7:0]          data_q;
  crc8cf_pkg::phase_e  phase_q, phase_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          remain_q, remain_d;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_end_q;

  logic       in_fire;
  logic       emit;
  logic       item_done;
  logic       last_byte;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic [7:0] plen_sat;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= crc8cf_pkg::DeviceIdReset;
    end else if (device_id_we_i) begin
      device_id_q <= device_id_i;
    end
  end

  // handshake control
  assign emit       = hold_valid_q && (!out_valid_q || out_ready_i);
  assign item_done  = emit && last_byte;
  assign in_ready_o = !hold_valid_q || item_done;
  assign in_fire    = in_valid_i && in_ready_o;

  // input holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_fire) begin
      hold_valid_q <= 1'b1;
    end else if (item_done) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= command_i;
      plen_q <= payload_len_i;
      data_q <= data_byte_i;
    end
  end

  // saturated payload length
  assign plen_sat = (plen_q > crc8cf_pkg::MaxPayload) ? crc8cf_pkg::MaxPayload : plen_q;

  // byte selection and next state of the emitter
  always_comb begin
    emit_byte = crc8cf_pkg::ReservedByte;
    emit_end  = 1'b0;
    last_byte = 1'b0;
    phase_d   = phase_q;
    remain_d  = remain_q;
    case (phase_q)
      crc8cf_pkg::PH_HDR: begin
        emit_byte = crc8cf_pkg::FrameHeader;
        phase_d   = crc8cf_pkg::PH_LEN;
      end
      crc8cf_pkg::PH_LEN: begin
        emit_byte = plen_sat + crc8cf_pkg::FrameOverhead;
        phase_d   = crc8cf_pkg::PH_DEV;
      end
      crc8cf_pkg::PH_DEV: begin
        emit_byte = device_id_q;
        phase_d   = crc8cf_pkg::PH_CMD;
      end
      crc8cf_pkg::PH_CMD: begin
        emit_byte = cmd_q;
        remain_d  = plen_sat;
        phase_d   = (plen_sat == 8'd0) ? crc8cf_pkg::PH_RSV : crc8cf_pkg::PH_DATA;
      end
      crc8cf_pkg::PH_DATA: begin
        emit_byte = data_q;
        remain_d  = remain_q - 8'd1;
        if (remain_d == 8'd0) begin
          phase_d = crc8cf_pkg::PH_RSV;
        end else begin
          last_byte = 1'b1;
          phase_d   = crc8cf_pkg::PH_DATA;
        end
      end
      crc8cf_pkg::PH_RSV: begin
        emit_byte = crc8cf_pkg::ReservedByte;
        phase_d   = crc8cf_pkg::PH_CRC;
      end
      crc8cf_pkg::PH_CRC: begin
        emit_byte = crc_q;
        emit_end  = 1'b1;
        last_byte = 1'b1;
        remain_d  = 8'd0;
        phase_d   = crc8cf_pkg::PH_HDR;
      end
      default: begin
        phase_d = crc8cf_pkg::PH_HDR;
      end
    endcase
  end

  // running crc, cleared once the crc byte goes out
  assign crc_d = emit_end ? 8'd0 : crc8cf_pkg::crc8_update(crc_q, emit_byte);

  // emitter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crc8cf_pkg::PH_HDR;
      crc_q    <= 8'd0;
      remain_q <= 8'd0;
    end else if (emit) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      remain_q <= remain_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_end_q  <= emit_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;

`ifndef ASSERT_OFF
  // with no item held the emitter sits at a frame or payload boundary
  a_idle_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_valid_q |-> (phase_q == crc8cf_pkg::PH_HDR || phase_q == crc8cf_pkg::PH_DATA))
    else $error("emitter left mid-item without a held item");

  // a frame starts from a clean crc and no pending payload
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == crc8cf_pkg::PH_HDR |-> (crc_q == 8'd0 && remain_q == 8'd0))
    else $error("frame start with stale crc or byte count");

  // payload count never exceeds the saturated maximum
  a_remain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= crc8cf_pkg::MaxPayload)
    else $error("remaining payload count out of range");

  // the crc byte always completes the held item
  a_crc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && phase_q == crc8cf_pkg::PH_CRC) |=> (phase_q == crc8cf_pkg::PH_HDR))
    else $error("frame did not close after crc byte");
`endif

endmodule

// ===== tb/crc8_command_framer_unit_tb.sv =====
// crc8_command_framer_unit_tb: self-checking testbench for the crc-8 command framer.
// Depends on crc8cf_pkg for frame constants and on crc8_command_framer_unit.
// A directed table runs first, then random frames; every output beat is checked.
`timescale 1ns / 1ps

module crc8_command_framer_unit_tb;

  localparam int RandItems   = 400;
  localparam int DrainCycles = 8;
  localparam int HoldAtBeat  = 100;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;

  // one directed stimulus row; t_len/t_dev are typed-in header bytes when typed is set
  typedef struct packed {
    logic       set_dev;
    logic [7:0] dev_val;
    logic [7:0] cmd;
    logic [7:0] plen;
    logic [7:0] data;
    logic       typed;
    logic [7:0] t_len;
    logic [7:0] t_dev;
  } vec_row_t;

  // one expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } frame_beat_t;

  localparam int NumVecs = 15;
  localparam vec_row_t DirVecs [NumVecs] = '{
    // reset device id, zero-length frame, data ignored
    '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 8'h06, 8'h01},
    // single payload byte, seven output beats
    '{1'b0, 8'h00, 8'hFF, 8'h01, 8'h00, 1'b1, 8'h07, 8'h01},
    // two-byte frame, second item carries junk command/length
    '{1'b0, 8'h00, 8'h5A, 8'h02, 8'hA5, 1'b1, 8'h08, 8'h01},
    '{1'b0, 8'h00, 8'h00, 8'hFF, 8'h5A, 1'b0, 8'h00, 8'h00},
    // device id at its maximum
    '{1'b1, 8'hFF, 8'h3C, 8'h00, 8'h00, 1'b1, 8'h06, 8'hFF},
    '{1'b0, 8'h00, 8'hC3, 8'h03, 8'hFF, 1'b1, 8'h09, 8'hFF},
    '{1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 8'h81, 8'h80, 8'h80, 1'b0, 8'h00, 8'h00},
    // device id at zero
    '{1'b1, 8'h00, 8'h01, 8'h00, 8'h7F, 1'b1, 8'h06, 8'h00},
    '{1'b0, 8'h00, 8'h80, 8'h01, 8'h01, 1'b1, 8'h07, 8'h00},
    // mid-range device id, four-byte frame
    '{1'b1, 8'hA5, 8'h7E, 8'h04, 8'h55, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 8'h12, 8'h34, 8'h00, 1'b0, 8'h00, 8'h00},
    // oversized length saturates to the maximum payload; random beats finish it
    '{1'b0, 8'h00, 8'hE7, 8'hFF, 8'h3C, 1'b1, 8'hFF, 8'hA5}
  };

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       dev_we      = 1'b0;
  logic [7:0] dev_data    = 8'h00;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] command     = 8'h00;
  logic [7:0] payload_len = 8'h00;
  logic [7:0] data_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_end;

  // framer model state
  logic [7:0]  dev_id_model = crc8cf_pkg::DeviceIdReset;
  logic [7:0]  crc_acc      = 8'h00;
  logic [7:0]  payload_left = 8'h00;
  frame_beat_t frame_bytes_due [$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  frames_built  = 0;
  int  bytes_checked = 0;
  int  cfg_writes    = 0;
  int  cycles        = 0;
  bit  send_quiet    = 1'b0;

  crc8_command_framer_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .device_id_we_i (dev_we),
    .device_id_i    (dev_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .payload_len_i  (payload_len),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_byte_o   (frame_byte),
    .frame_end_o    (frame_end)
  );

  always #4 clk = ~clk;

  // serial form of the reflected crc-8, one bit at a time lsb first
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ crc8cf_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic void push_frame_byte(input logic [7:0] b);
    frame_bytes_due.push_back('{data: b, is_end: 1'b0});
    crc_acc = crc8_shift(crc_acc, b);
  endfunction

  // expected frame bytes for one input beat; returns how many were queued
  function automatic int predict_frame_item(input logic [7:0] cmd, input logic [7:0] plen,
                                            input logic [7:0] data);
    logic [7:0] len;
    int         n;
    n = 0;
    if (payload_left == 0) begin
      len     = (plen > crc8cf_pkg::MaxPayload) ? crc8cf_pkg::MaxPayload : plen;
      crc_acc = 8'h00;
      push_frame_byte(crc8cf_pkg::FrameHeader);
      push_frame_byte(len + crc8cf_pkg::FrameOverhead);
      push_frame_byte(dev_id_model);
      push_frame_byte(cmd);
      n = 4;
      frames_built++;
      if (len != 0) begin
        push_frame_byte(data);
        payload_left = len - 8'd1;
        n++;
      end
    end else begin
      push_frame_byte(data);
      payload_left = payload_left - 8'd1;
      n = 1;
    end
    // trailer: reserved byte then the crc, which closes the frame
    if (payload_left == 0) begin
      push_frame_byte(crc8cf_pkg::ReservedByte);
      frame_bytes_due.push_back('{data: crc_acc, is_end: 1'b1});
      crc_acc = 8'h00;
      n += 2;
    end
    return n;
  endfunction

  // offer one input beat after a random gap (none when quiet), hold it until accepted
  task automatic send_item(input logic [7:0] cmd, input logic [7:0] plen, input logic [7:0] data,
                           input bit typed, input logic [7:0] t_len, input logic [7:0] t_dev);
    int          gap;
    int          n;
    int          first;
    frame_beat_t tmp;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    payload_len <= plen;
    data_byte   <= data;
    n = predict_frame_item(cmd, plen, data);
    // typed-in length and device id bytes replace the computed ones
    if (typed) begin
      first = frame_bytes_due.size() - n;
      tmp = frame_bytes_due[first + 1];
      tmp.data = t_len;
      frame_bytes_due[first + 1] = tmp;
      tmp = frame_bytes_due[first + 2];
      tmp.data = t_dev;
      frame_bytes_due[first + 2] = tmp;
    end
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // write the device id once the framer has drained
  task automatic write_device_id(input logic [7:0] val);
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_bytes_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    dev_we   <= 1'b1;
    dev_data <= val;
    @(posedge clk);
    dev_we       <= 1'b0;
    dev_id_model = val;
    cfg_writes++;
  endtask

  // sender: reset, directed table, then random frames
  initial begin : feed
    int         i;
    int         next_cfg;
    int         r;
    logic [7:0] plen;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirVecs[k]) begin
      if (DirVecs[k].set_dev) begin
        write_device_id(DirVecs[k].dev_val);
      end
      send_item(DirVecs[k].cmd, DirVecs[k].plen, DirVecs[k].data,
                DirVecs[k].typed, DirVecs[k].t_len, DirVecs[k].t_dev);
    end

    next_cfg = 260;
    for (i = 0; i < RandItems || payload_left != 0; i++) begin
      if (payload_left == 0) begin
        if (i >= next_cfg) begin
          write_device_id(8'($urandom_range(0, 255)));
          next_cfg += 50;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_quiet = ~send_quiet;
        end
        // mostly short frames, now and then a full-size or oversized one
        r = $urandom_range(0, 99);
        if (r < 15) begin
          plen = 8'd0;
        end else if (r < 35) begin
          plen = 8'd1;
        end else if (r < 85) begin
          plen = 8'($urandom_range(2, 12));
        end else if (r < 97) begin
          plen = 8'($urandom_range(13, 40));
        end else begin
          plen = 8'($urandom_range(249, 255));
        end
      end else begin
        plen = 8'($urandom_range(0, 255));
      end
      send_item(8'($urandom_range(0, 255)), plen, 8'($urandom_range(0, 255)),
                1'b0, 8'h00, 8'h00);
    end
    in_valid <= 1'b0;

    // drain, then give the framer time to show any stray beat
    do @(posedge clk); while (frame_bytes_due.size() != 0);
    repeat (4 * DrainCycles) @(posedge clk);
    $display("covered %0d frames from %0d input beats, %0d output beats checked",
             frames_built, items_sent, bytes_checked);
    $display("device id written %0d times incl. both extremes, one long output hold-off",
             cfg_writes);
    if (errors == 0) begin
      $display("crc8_command_framer_unit test passed");
    end else begin
      $display("crc8_command_framer_unit test failed");
    end
    $finish;
  end

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin : drain
    int stall;
    int beats;
    bit quiet;
    beats = 0;
    quiet = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (beats == HoldAtBeat) begin
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      beats++;
      if (beats % 32 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // output check against the oldest expected beat
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected beat: frame_byte %02h frame_end %0b", frame_byte, frame_end);
        errors++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte mismatch: expected %02h actual %02h", want.data, frame_byte);
          errors++;
        end
        if (frame_end !== want.is_end) begin
          $error("frame_end mismatch: expected %0b actual %0b", want.is_end, frame_end);
          errors++;
        end
        bytes_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("crc8_command_framer_unit test failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/crc8cf_pkg.sv
rtl/core/crc8_command_framer_unit.sv
tb/crc8_command_framer_unit_tb.sv
